FILE: rtl/bcr_pkg.sv
// Package with shared types and constants of the button combo resolver.
package bcr_pkg;

    localparam int PENDING_DEPTH_DEF = 8;
    localparam int BUTTON_COUNT_DEF  = 8;
    localparam int COMBO_COUNT_DEF   = 7;

    localparam int N_COMBO_REGS = 7;
    localparam int CFG_AW       = 4;
    localparam int CFG_DW       = 16;

    localparam logic [CFG_AW-1:0] REG_TIMEOUT     = 4'd0;
    localparam logic [CFG_AW-1:0] REG_COMBO_FIRST = 4'd1;
    localparam logic [CFG_AW-1:0] REG_COMBO_LAST  = 4'd7;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0] COMBO_RESET [N_COMBO_REGS] = '{
        8'h03, 8'h09, 8'h0C, 8'h18, 8'h28, 8'h48, 8'h88
    };

    localparam logic REQ_BUTTON = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic KIND_COMBO  = 1'b0;
    localparam logic KIND_SINGLE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  button;
        logic [2:0]  event_code;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [2:0] combo_index;
        logic [2:0] out_button;
        logic [2:0] out_event;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [2:0] button;
        logic [2:0] event_code;
    } t_entry;

endpackage

FILE: rtl/button_combo_resolver_top.sv
// Top level of the button combo resolver: sequencer, config registers, result register.
// A tick or ignored event passes S_CHECK and returns to idle; a stored event also passes S_STORE.
// A resolution reads each pending entry into the button mask, compares the combos in order,
// and, if none matches, emits every pending entry as a single action.
// One transaction at a time; results come one per strobe and cannot be stalled.
// Synchronous active-low reset restores config defaults and empties the window.
module button_combo_resolver_top
    import bcr_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int BUTTON_COUNT  = BUTTON_COUNT_DEF,
    parameter int COMBO_COUNT   = COMBO_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output logic              o_strobe,
    output t_out              o_result
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
    localparam logic [3:0] BTN_LIMIT = 4'(BUTTON_COUNT);
    localparam logic [2:0] CI_LAST = 3'(COMBO_COUNT - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_MASK_RD  = 3'd2;
    localparam logic [2:0] S_MASK_ACC = 3'd3;
    localparam logic [2:0] S_COMBO    = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_OUT = 3'd6;
    localparam logic [2:0] S_STORE    = 3'd7;

    logic [2:0]    r_state, n_state;
    t_in           r_item, n_item;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [2:0]    r_ci, n_ci;
    logic [7:0]    r_mask, n_mask;
    logic [31:0]   r_wstart, n_wstart;
    logic          r_wopen, n_wopen;
    logic          r_stb, n_stb;
    t_out          r_out, n_out;

    logic [15:0]   r_timeout;
    logic [7:0]    r_combo [N_COMBO_REGS];

    logic [31:0]   elapsed;
    logic          expired;
    logic          item_ok;
    logic          at_last;
    logic [7:0]    cur_combo;
    logic          mem_we;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    bcr_pend_mem #(
        .DEPTH (PENDING_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign elapsed   = r_item.now_ms - r_wstart;
    assign expired   = r_wopen && (elapsed > {16'd0, r_timeout});
    assign item_ok   = (r_item.event_code != 3'd0) && ({1'b0, r_item.button} < BTN_LIMIT);
    assign at_last   = (r_idx == r_cnt - CW'(1));
    assign cur_combo = r_combo[r_ci];
    assign mem_wdata = '{button: r_item.button, event_code: r_item.event_code};
    assign mem_we    = (r_state == S_STORE) && (r_cnt < DEPTH_C);

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            for (int k = 0; k < N_COMBO_REGS; k++) begin
                r_combo[k] <= COMBO_RESET[k];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_TIMEOUT) begin
                r_timeout <= i_cfg_wdata;
            end else if (i_cfg_addr inside {[REG_COMBO_FIRST:REG_COMBO_LAST]}) begin
                r_combo[3'(i_cfg_addr - REG_COMBO_FIRST)] <= i_cfg_wdata[7:0];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_ci     = r_ci;
        n_mask   = r_mask;
        n_wstart = r_wstart;
        n_wopen  = r_wopen;
        n_stb    = 1'b0;
        n_out    = r_out;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx  = '0;
                n_mask = '0;
                if (r_item.req_type == REQ_BUTTON && !item_ok) begin
                    n_state = S_IDLE;
                end else if (expired) begin
                    if (r_cnt == '0) begin
                        n_wopen = 1'b0;
                        n_state = (r_item.req_type == REQ_TICK) ? S_IDLE : S_STORE;
                    end else begin
                        n_state = S_MASK_RD;
                    end
                end else begin
                    n_state = (r_item.req_type == REQ_TICK) ? S_IDLE : S_STORE;
                end
            end
            S_MASK_RD: begin
                n_state = S_MASK_ACC;
            end
            S_MASK_ACC: begin
                n_mask = r_mask | (8'd1 << mem_rdata.button);
                if (at_last) begin
                    n_ci    = '0;
                    n_state = S_COMBO;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_MASK_RD;
                end
            end
            S_COMBO: begin
                if (cur_combo != 8'd0 && cur_combo == r_mask) begin
                    n_stb   = 1'b1;
                    n_out   = '{kind: KIND_COMBO, combo_index: r_ci, out_button: 3'd0,
                                out_event: 3'd0, last: 1'b1};
                    n_cnt   = '0;
                    n_wopen = 1'b0;
                    n_state = (r_item.req_type == REQ_TICK) ? S_IDLE : S_STORE;
                end else if (r_ci == CI_LAST) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_ci = r_ci + 3'd1;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                n_stb = 1'b1;
                n_out = '{kind: KIND_SINGLE, combo_index: 3'd0, out_button: mem_rdata.button,
                          out_event: mem_rdata.event_code, last: at_last};
                if (at_last) begin
                    n_cnt   = '0;
                    n_wopen = 1'b0;
                    n_state = (r_item.req_type == REQ_TICK) ? S_IDLE : S_STORE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_EMIT_RD;
                end
            end
            S_STORE: begin
                if (r_cnt < DEPTH_C) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_wopen  = 1'b1;
                n_wstart = r_item.now_ms;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_wstart <= '0;
            r_wopen  <= 1'b0;
            r_stb    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_wstart <= n_wstart;
            r_wopen  <= n_wopen;
            r_stb    <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_ci   <= n_ci;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

endmodule

FILE: rtl/bcr_pend_mem.sv
// Pending event buffer with one write port and one registered read port.
module bcr_pend_mem
    import bcr_pkg::*;
#(
    parameter int DEPTH = PENDING_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: rtl/bcr_checker.sv
// Port-level checker of the button combo resolver and its bind to the top level.
module bcr_checker
    import bcr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_combo_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_COMBO |->
            o_result.last && o_result.out_button == 3'd0 && o_result.out_event == 3'd0)
        else $error("combo result malformed");

    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_SINGLE |-> o_result.combo_index == 3'd0)
        else $error("single action carries combo index");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("result strobe right after final result");

endmodule

bind button_combo_resolver_top bcr_checker u_bcr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
